>>> rtl/core/tdp_pkg.sv
// ----------------------------------------------------------------------------
// tdp_pkg: shared types and constants for the 2-D parity packet encoder
// Holds the channel item types, the packer-to-queue result bundle and the
// function that forms a 64-bit packet word from 49 data bits.
// ----------------------------------------------------------------------------
package tdp_pkg;

  localparam int unsigned ROW_BITS    = 7;
  localparam int unsigned ROWS        = 7;
  localparam int unsigned PKT_BITS    = ROW_BITS * ROWS;   // 49 data bits
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned CNT_BITS    = 6;
  // A byte completes a packet when this many bits or more are already held.
  localparam logic [CNT_BITS-1:0] FULL_AT = CNT_BITS'(PKT_BITS - BYTE_BITS);

  typedef struct packed {
    logic [BYTE_BITS-1:0] data_byte;
    logic                 end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] packet_word;
    logic                 final_packet;
  } out_item_t;

  // Up to two results per accepted item; slot 0 is always the earlier one.
  typedef struct packed {
    logic      vld0;
    out_item_t item0;
    logic      vld1;
    out_item_t item1;
  } res_t;

  // Data bit p of the packet sits at d[PKT_BITS-1-p]. Unfilled bits are zero,
  // so each row's parity is simply the XOR of its seven data bits.
  function automatic logic [WORD_BITS-1:0] build_word(input logic [PKT_BITS-1:0] d);
    logic [WORD_BITS-1:0] w;
    logic [ROW_BITS-1:0]  row;
    logic [7:0]           rb;
    logic [7:0]           col;
    w   = '0;
    col = '0;
    for (int r = 0; r < ROWS; r++) begin
      row = d[PKT_BITS-1-ROW_BITS*r -: ROW_BITS];
      rb  = {row, ^row};
      w[WORD_BITS-1-8*r -: 8] = rb;
      col = col ^ rb;
    end
    w[7:0] = col;
    return w;
  endfunction

endpackage

>>> rtl/core/tdp_packer.sv
// ----------------------------------------------------------------------------
// tdp_packer: bit packing and packet formation
// Places each accepted byte into the 49-bit packet store at the current fill
// position and emits a finished packet, plus a flushed partial one at the
// end of a stream.
// ----------------------------------------------------------------------------
module tdp_packer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  tdp_pkg::in_item_t in_item,
  output tdp_pkg::res_t     res
);

  localparam int unsigned PB = tdp_pkg::PKT_BITS;
  localparam int unsigned BB = tdp_pkg::BYTE_BITS;
  localparam int unsigned CB = tdp_pkg::CNT_BITS;

  logic [PB-1:0]    data_r, data_nxt;
  logic [CB-1:0]    cnt_r, cnt_nxt;
  logic [PB+BB-1:0] merged;
  logic             full;
  logic             last;
  logic [PB-1:0]    rest;

  // Drop the new byte in right after the bits already held.
  assign merged = {data_r, {BB{1'b0}}} | ({in_item.data_byte, {PB{1'b0}}} >> cnt_r);
  assign full   = (cnt_r >= tdp_pkg::FULL_AT);
  assign last   = in_item.end_of_data;
  // Bits that spill past a completed packet start the next one.
  assign rest   = {merged[BB-1:0], {(PB-BB){1'b0}}};

  // Next state of the store and the fill count.
  always_comb begin
    if (last) begin
      data_nxt = '0;
      cnt_nxt  = '0;
    end else if (full) begin
      data_nxt = rest;
      cnt_nxt  = cnt_r - tdp_pkg::FULL_AT;
    end else begin
      data_nxt = merged[PB+BB-1:BB];
      cnt_nxt  = cnt_r + CB'(BB);
    end
  end

  // Results caused by this item, in order.
  always_comb begin
    res = '0;
    res.item0.packet_word = tdp_pkg::build_word(merged[PB+BB-1:BB]);
    res.item1.packet_word = tdp_pkg::build_word(rest);
    res.item1.final_packet = 1'b1;
    if (in_fire) begin
      if (full) begin
        res.vld0 = 1'b1;
        if (last && (cnt_r != tdp_pkg::FULL_AT)) begin
          res.vld1 = 1'b1;
        end else begin
          res.item0.final_packet = last;
        end
      end else if (last) begin
        res.vld0 = 1'b1;
        res.item0.final_packet = 1'b1;
      end
    end
  end

  // Store and count registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
      cnt_r  <= '0;
    end else if (in_fire) begin
      data_r <= data_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/tdp_out_fifo.sv
// ----------------------------------------------------------------------------
// tdp_out_fifo: result queue
// Small queue of finished packets that takes up to two items a cycle and
// hands one item a cycle to the result channel while out_stall is low.
// ----------------------------------------------------------------------------
module tdp_out_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tdp_pkg::res_t                  wr,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tdp_pkg::out_item_t             out_item,
  output logic [$clog2(DEPTH+1)-1:0]     level
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tdp_pkg::out_item_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  logic [1:0]    n_wr;

  function automatic logic [AW-1:0] incr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_p1 = incr(wr_ptr_r);
  assign n_wr      = {1'b0, wr.vld0} + {1'b0, wr.vld1};
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign level     = cnt_r;

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (wr.vld1) begin
      wr_ptr_nxt = incr(wr_ptr_p1);
    end else if (wr.vld0) begin
      wr_ptr_nxt = wr_ptr_p1;
    end
    rd_ptr_nxt = pop ? incr(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(n_wr) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage; the second result goes one slot after the first.
  always_ff @(posedge clk) begin
    if (wr.vld0) begin
      mem[wr_ptr_r] <= wr.item0;
    end
    if (wr.vld1) begin
      mem[wr_ptr_p1] <= wr.item1;
    end
  end

endmodule

>>> rtl/core/two_d_parity_packet_encoder_core.sv
// ----------------------------------------------------------------------------
// two_d_parity_packet_encoder_core: 7x7 two-dimensional parity encoder
// Packs a byte stream into 64-bit packets of seven parity rows and one
// column parity byte, flushing a zero-padded packet at the end of a stream.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle unless in_stall is high. Each byte is
// merged into the packet store by a single variable shift, and a packet is
// formed with its row and column parity in the same cycle and registered
// in the result queue. Results leave through a queue of FIFO_DEPTH entries
// at one item per cycle unless out_stall is high. A byte may cause two
// results (a full packet and the flushed final one), so in_stall rises
// while fewer than two queue entries are free. FIFO_DEPTH ranges from 3
// to 16; at 4 or more, a byte stream is taken at one item per cycle while
// the result side keeps taking items.
module two_d_parity_packet_encoder_core #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tdp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tdp_pkg::out_item_t out_item
);

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  tdp_pkg::res_t res;
  logic [CW-1:0] level;
  logic          in_fire;

  // Hold off input unless the queue can take two results.
  assign in_stall = (level > CW'(FIFO_DEPTH - 2));
  assign in_fire  = in_valid && !in_stall;

  tdp_packer u_packer (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_item),
    .res     (res)
  );

  tdp_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .level     (level)
  );

  // A second result only ever follows a first one in the same cycle.
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld1 |-> res.vld0)
    else $error("second result without a first");

  // With two results, only the later one closes the stream.
  a_final_order: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld1 |-> (res.item1.final_packet && !res.item0.final_packet))
    else $error("final packet flag on the wrong result");

  // The stall margin keeps the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    level <= CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  // Results are only produced for an accepted item.
  a_res_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld0 |-> in_fire)
    else $error("result without an accepted item");

endmodule
